/* rtl/ladder_filter_four_pole_defines.svh */
// ----------------------------------------------------------------------------
// ladder filter assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef LADDER_FILTER_FOUR_POLE_DEFINES_SVH
`define LADDER_FILTER_FOUR_POLE_DEFINES_SVH

// same-cycle implication
`define LFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/lfp_pkg.sv */
// ----------------------------------------------------------------------------
// lfp_pkg
// shared widths, control codes and the microcode program of the ladder filter
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int LFP_CHANNEL_COUNT   = 2;
    localparam int LFP_STATE_FRAC_BITS = 20;

    localparam int LFP_SAMPLE_W    = 16;
    localparam int LFP_SAMPLE_FRAC = 15;
    localparam int LFP_COEF_W      = 16;
    localparam int LFP_MODE_W      = 2;
    localparam int LFP_STATE_W     = 24;
    localparam int LFP_COEF_SHIFT  = 12;
    localparam int LFP_SIXTH_SHIFT = 16;
    localparam int LFP_SIXTH_Q16   = 10923;
    localparam int LFP_CFG_ADDR_W  = 2;

    localparam int LFP_STAGE_COUNT = 4;
    localparam int LFP_STAGE_W     = 2;
    localparam int LFP_STEP_W      = 4;

    // configuration register indexes
    localparam logic [LFP_CFG_ADDR_W-1:0] CFG_COEF_P = 2'd0;
    localparam logic [LFP_CFG_ADDR_W-1:0] CFG_COEF_F = 2'd1;
    localparam logic [LFP_CFG_ADDR_W-1:0] CFG_COEF_Q = 2'd2;
    localparam logic [LFP_CFG_ADDR_W-1:0] CFG_MODE   = 2'd3;

    // output taps
    localparam logic [LFP_MODE_W-1:0] MODE_LP = 2'd0;
    localparam logic [LFP_MODE_W-1:0] MODE_HP = 2'd1;
    localparam logic [LFP_MODE_W-1:0] MODE_BP = 2'd2;

    // multiplier operand a
    localparam logic [2:0] A_S4   = 3'd0;
    localparam logic [2:0] A_SUM  = 3'd1;
    localparam logic [2:0] A_OLD  = 3'd2;
    localparam logic [2:0] A_N4   = 3'd3;
    localparam logic [2:0] A_SQ   = 3'd4;
    localparam logic [2:0] A_CUBE = 3'd5;

    // multiplier operand b
    localparam logic [2:0] B_Q     = 3'd0;
    localparam logic [2:0] B_P     = 3'd1;
    localparam logic [2:0] B_F     = 3'd2;
    localparam logic [2:0] B_N4    = 3'd3;
    localparam logic [2:0] B_SIXTH = 3'd4;

    // accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_SUB  = 2'd2;

    // write-back operation
    localparam logic [2:0] WB_NONE  = 3'd0;
    localparam logic [2:0] WB_U     = 3'd1;
    localparam logic [2:0] WB_STAGE = 3'd2;
    localparam logic [2:0] WB_SQ    = 3'd3;
    localparam logic [2:0] WB_CUBE  = 3'd4;
    localparam logic [2:0] WB_CLIP  = 3'd5;
    localparam logic [2:0] WB_OUT   = 3'd6;

    // sequencing
    localparam logic [2:0] J_NEXT    = 3'd0;
    localparam logic [2:0] J_WAIT_IN = 3'd1;
    localparam logic [2:0] J_LOOP    = 3'd2;
    localparam logic [2:0] J_OUT     = 3'd3;
    localparam logic [2:0] J_GOTO    = 3'd4;

    // program addresses
    localparam logic [LFP_STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [LFP_STEP_W-1:0] STEP_FB_MUL = 4'd1;
    localparam logic [LFP_STEP_W-1:0] STEP_U_WB   = 4'd2;
    localparam logic [LFP_STEP_W-1:0] STEP_P_MUL  = 4'd3;
    localparam logic [LFP_STEP_W-1:0] STEP_F_MAC  = 4'd4;
    localparam logic [LFP_STEP_W-1:0] STEP_N_WB   = 4'd5;
    localparam logic [LFP_STEP_W-1:0] STEP_SQ_MUL = 4'd6;
    localparam logic [LFP_STEP_W-1:0] STEP_SQ_WB  = 4'd7;
    localparam logic [LFP_STEP_W-1:0] STEP_CU_MUL = 4'd8;
    localparam logic [LFP_STEP_W-1:0] STEP_CU_WB  = 4'd9;
    localparam logic [LFP_STEP_W-1:0] STEP_SX_MUL = 4'd10;
    localparam logic [LFP_STEP_W-1:0] STEP_CLIP   = 4'd11;
    localparam logic [LFP_STEP_W-1:0] STEP_OUT    = 4'd12;

    typedef struct packed {
        logic [2:0]            jmp;
        logic [LFP_STEP_W-1:0] target;
        logic [2:0]            a_sel;
        logic [2:0]            b_sel;
        logic [1:0]            acc_op;
        logic [2:0]            wb_op;
    } ucode_t;

    typedef struct packed {
        logic       load;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [1:0] acc_op;
        logic [2:0] wb_op;
    } ctl_t;

    function automatic ucode_t lfp_ucode(input logic [LFP_STEP_W-1:0] step);
        ucode_t w;
        w.jmp    = J_NEXT;
        w.target = STEP_IDLE;
        w.a_sel  = A_S4;
        w.b_sel  = B_Q;
        w.acc_op = ACC_HOLD;
        w.wb_op  = WB_NONE;
        unique case (step)
            STEP_IDLE:   w.jmp = J_WAIT_IN;
            STEP_FB_MUL:
            begin
                w.a_sel  = A_S4;
                w.b_sel  = B_Q;
                w.acc_op = ACC_LOAD;
            end
            STEP_U_WB:   w.wb_op = WB_U;
            STEP_P_MUL:
            begin
                w.a_sel  = A_SUM;
                w.b_sel  = B_P;
                w.acc_op = ACC_LOAD;
            end
            STEP_F_MAC:
            begin
                w.a_sel  = A_OLD;
                w.b_sel  = B_F;
                w.acc_op = ACC_SUB;
            end
            STEP_N_WB:
            begin
                w.wb_op  = WB_STAGE;
                w.jmp    = J_LOOP;
                w.target = STEP_P_MUL;
            end
            STEP_SQ_MUL:
            begin
                w.a_sel  = A_N4;
                w.b_sel  = B_N4;
                w.acc_op = ACC_LOAD;
            end
            STEP_SQ_WB:  w.wb_op = WB_SQ;
            STEP_CU_MUL:
            begin
                w.a_sel  = A_SQ;
                w.b_sel  = B_N4;
                w.acc_op = ACC_LOAD;
            end
            STEP_CU_WB:  w.wb_op = WB_CUBE;
            STEP_SX_MUL:
            begin
                w.a_sel  = A_CUBE;
                w.b_sel  = B_SIXTH;
                w.acc_op = ACC_LOAD;
            end
            STEP_CLIP:   w.wb_op = WB_CLIP;
            STEP_OUT:
            begin
                w.wb_op  = WB_OUT;
                w.jmp    = J_OUT;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.jmp    = J_GOTO;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/ladder_filter_four_pole.sv */
// ----------------------------------------------------------------------------
// ladder_filter_four_pole
// four-pole resonant ladder filter, per-channel state, microcoded datapath
// ----------------------------------------------------------------------------
// input stream: one request carries a Q1.15 sample in tdata and the channel
// number in tuser; output stream: one filtered Q1.15 sample per request.
// configuration: cfg_we with cfg_addr 0 p, 1 f, 2 q (signed Q3.12), 3 output
// mode (0 lowpass, 1 highpass, 2 bandpass, 3 lowpass); write only while idle.
// one item at a time through a single shared multiplier run by a 13-word
// microprogram; the four ladder stages loop over three of its words.
// an accepted request runs the whole program before the next is accepted; the
// pace is set by the chain of dependent products (feedback, two per stage,
// square, cube, cube/6) through the one multiplier, with a write-back step
// after the feedback, after each stage's pair and after each of the others.
// the result sits in an output register, so the next request is accepted and
// worked on while it waits; if the receiver stalls, the program holds at its
// last step until the output register frees.
// reset: state, config and control registers clear to zero, no clearing pass.
// ----------------------------------------------------------------------------
module ladder_filter_four_pole #(
    parameter int CHANNEL_COUNT   = lfp_pkg::LFP_CHANNEL_COUNT,
    parameter int STATE_FRAC_BITS = lfp_pkg::LFP_STATE_FRAC_BITS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [lfp_pkg::LFP_SAMPLE_W-1:0]        s_axis_tdata,  // sample_in
    input  logic [0:0]                              s_axis_tuser,  // channel_sel
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [lfp_pkg::LFP_SAMPLE_W-1:0]        m_axis_tdata,  // sample_out
    input  logic                                    cfg_we,
    input  logic [lfp_pkg::LFP_CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [lfp_pkg::LFP_COEF_W-1:0]          cfg_data
);
    import lfp_pkg::*;

    logic signed [LFP_COEF_W-1:0]   coef_p_reg;
    logic signed [LFP_COEF_W-1:0]   coef_f_reg;
    logic signed [LFP_COEF_W-1:0]   coef_q_reg;
    logic [LFP_MODE_W-1:0]          mode_reg;
    logic                           out_valid_reg;
    logic [LFP_SAMPLE_W-1:0]        out_data_reg;
    logic                           out_free;
    ctl_t                           ctl;
    logic signed [LFP_SAMPLE_W-1:0] dp_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_p_reg <= '0;
            coef_f_reg <= '0;
            coef_q_reg <= '0;
            mode_reg   <= MODE_LP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_COEF_P: coef_p_reg <= cfg_data;
                CFG_COEF_F: coef_f_reg <= cfg_data;
                CFG_COEF_Q: coef_q_reg <= cfg_data;
                CFG_MODE:   mode_reg   <= cfg_data[LFP_MODE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_axis_tready;

    lfp_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .out_free (out_free),
        .ctl      (ctl)
    );

    lfp_datapath #(
        .CHANNEL_COUNT   (CHANNEL_COUNT),
        .STATE_FRAC_BITS (STATE_FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sample_in   (signed'(s_axis_tdata)),
        .channel_sel (s_axis_tuser[0]),
        .coef_p      (coef_p_reg),
        .coef_f      (coef_f_reg),
        .coef_q      (coef_q_reg),
        .output_mode (mode_reg),
        .sample_out  (dp_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.wb_op == WB_OUT)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wb_op == WB_OUT)
        begin
            out_data_reg <= dp_out;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* rtl/lfp_sequencer.sv */
// ----------------------------------------------------------------------------
// lfp_sequencer
// step counter over the microcode program, stage loop counter and handshakes
// ----------------------------------------------------------------------------
`include "ladder_filter_four_pole_defines.svh"

module lfp_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic          out_free,
    output lfp_pkg::ctl_t ctl
);
    import lfp_pkg::*;

    localparam logic [LFP_STAGE_W-1:0] STAGE_LAST = LFP_STAGE_W'(LFP_STAGE_COUNT - 1);

    logic [LFP_STEP_W-1:0]  step_reg;
    logic [LFP_STEP_W-1:0]  step_next;
    logic [LFP_STAGE_W-1:0] stage_reg;
    logic [LFP_STAGE_W-1:0] stage_next;
    ucode_t                 uc;
    logic                   accept;
    logic                   out_stall;

    assign uc        = lfp_ucode(step_reg);
    assign in_ready  = (uc.jmp == J_WAIT_IN);
    assign accept    = in_valid && in_ready;
    assign out_stall = (uc.jmp == J_OUT) && !out_free;

    always_comb
    begin
        step_next  = step_reg;
        stage_next = stage_reg;
        unique case (uc.jmp)
            J_NEXT:    step_next = step_reg + 1'b1;
            J_WAIT_IN:
            begin
                if (in_valid)
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            J_LOOP:
            begin
                if (stage_reg == STAGE_LAST)
                begin
                    stage_next = '0;
                    step_next  = step_reg + 1'b1;
                end
                else
                begin
                    stage_next = stage_reg + 1'b1;
                    step_next  = uc.target;
                end
            end
            J_OUT:
            begin
                if (out_free)
                begin
                    step_next = uc.target;
                end
            end
            J_GOTO:    step_next = uc.target;
            default:   step_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= STEP_IDLE;
            stage_reg <= '0;
        end
        else
        begin
            step_reg  <= step_next;
            stage_reg <= stage_next;
        end
    end

    always_comb
    begin
        ctl.load   = accept;
        ctl.a_sel  = uc.a_sel;
        ctl.b_sel  = uc.b_sel;
        ctl.acc_op = uc.acc_op;
        // result and state write-back wait until the output register is free
        ctl.wb_op  = out_stall ? WB_NONE : uc.wb_op;
    end

    `LFP_ASSERT_IMP(a_idle_stage_clear, step_reg == STEP_IDLE, stage_reg == '0, "stage loop not cleared at idle")
    `LFP_ASSERT_IMP(a_out_when_free, ctl.wb_op == WB_OUT, out_free, "result written while output still held")
    `LFP_ASSERT_NEXT(a_accept_starts, accept, step_reg == STEP_FB_MUL, "accepted request did not start program")
    `LFP_ASSERT_IMP(a_step_in_program, 1'b1, step_reg <= STEP_OUT, "step counter left the program")

endmodule

/* rtl/lfp_datapath.sv */
// ----------------------------------------------------------------------------
// lfp_datapath
// shared multiplier and accumulator, working registers and per-channel state
// ----------------------------------------------------------------------------
module lfp_datapath #(
    parameter int CHANNEL_COUNT   = lfp_pkg::LFP_CHANNEL_COUNT,
    parameter int STATE_FRAC_BITS = lfp_pkg::LFP_STATE_FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lfp_pkg::ctl_t                          ctl,
    input  logic signed [lfp_pkg::LFP_SAMPLE_W-1:0] sample_in,
    input  logic                                   channel_sel,
    input  logic signed [lfp_pkg::LFP_COEF_W-1:0]   coef_p,
    input  logic signed [lfp_pkg::LFP_COEF_W-1:0]   coef_f,
    input  logic signed [lfp_pkg::LFP_COEF_W-1:0]   coef_q,
    input  logic [lfp_pkg::LFP_MODE_W-1:0]          output_mode,
    output logic signed [lfp_pkg::LFP_SAMPLE_W-1:0] sample_out
);
    import lfp_pkg::*;

    localparam int X_W       = STATE_FRAC_BITS + 1;
    localparam int SQ_W      = 2 * LFP_STATE_W - STATE_FRAC_BITS;
    localparam int CUBE_W    = 3 * LFP_STATE_W - 2 * STATE_FRAC_BITS;
    localparam int B_W       = LFP_STATE_W + 1;
    localparam int A_MAX0    = (SQ_W > CUBE_W) ? SQ_W : CUBE_W;
    localparam int A_W       = (A_MAX0 > B_W) ? A_MAX0 : B_W;
    localparam int P_W       = A_W + B_W;
    localparam int ACC_W     = P_W + 1;
    localparam int CH_W      = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
    localparam int OUT_SHIFT = STATE_FRAC_BITS - LFP_SAMPLE_FRAC;
    localparam int TAP_W     = LFP_STATE_W + 4;

    localparam logic signed [ACC_W-1:0] RND_COEF  = ACC_W'(2 ** (LFP_COEF_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] RND_SIXTH = ACC_W'(2 ** (LFP_SIXTH_SHIFT - 1));
    localparam logic signed [ACC_W-1:0] ST_HI     = ACC_W'(2 ** (LFP_STATE_W - 1) - 1);
    localparam logic signed [ACC_W-1:0] ST_LO     = -ACC_W'(2 ** (LFP_STATE_W - 1));
    localparam logic signed [TAP_W-1:0] OUT_HALF  = (TAP_W'(1) <<< OUT_SHIFT) >>> 1;
    localparam logic signed [TAP_W-1:0] OUT_HI    = TAP_W'(2 ** (LFP_SAMPLE_W - 1) - 1);
    localparam logic signed [TAP_W-1:0] OUT_LO    = -TAP_W'(2 ** (LFP_SAMPLE_W - 1));
    localparam logic signed [B_W-1:0]   SIXTH     = B_W'(LFP_SIXTH_Q16);

    typedef struct packed {
        logic signed [LFP_STATE_W-1:0] held;
        logic signed [LFP_STATE_W-1:0] s1;
        logic signed [LFP_STATE_W-1:0] s2;
        logic signed [LFP_STATE_W-1:0] s3;
        logic signed [LFP_STATE_W-1:0] s4;
    } chan_state_t;

    function automatic logic signed [LFP_STATE_W-1:0] sat_state(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [ACC_W-1:0] r;
        priority if (v > ST_HI)
        begin
            r = ST_HI;
        end
        else if (v < ST_LO)
        begin
            r = ST_LO;
        end
        else
        begin
            r = v;
        end
        return r[LFP_STATE_W-1:0];
    endfunction

    chan_state_t                   state_reg [CHANNEL_COUNT];
    logic [CH_W-1:0]               ch_idx;
    logic [CH_W-1:0]               ch_reg;
    logic signed [X_W-1:0]         x_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [LFP_STATE_W-1:0] u_reg;
    logic signed [LFP_STATE_W-1:0] cur_reg;
    logic signed [LFP_STATE_W-1:0] w_reg  [5];
    logic signed [LFP_STATE_W-1:0] nq_reg [LFP_STAGE_COUNT];
    logic signed [SQ_W-1:0]        sq_reg;
    logic signed [CUBE_W-1:0]      cube_reg;

    logic signed [A_W-1:0]         a_op;
    logic signed [B_W-1:0]         b_op;
    logic signed [P_W-1:0]         prod;
    logic signed [ACC_W-1:0]       acc_rnd_coef;
    logic signed [ACC_W-1:0]       acc_rnd_sixth;
    logic signed [LFP_STATE_W-1:0] u_val;
    logic signed [LFP_STATE_W-1:0] stage_val;
    logic signed [LFP_STATE_W-1:0] clip_val;
    logic signed [TAP_W-1:0]       band_diff;
    logic signed [TAP_W-1:0]       tap;
    logic signed [TAP_W-1:0]       tap_rnd;

    assign ch_idx = (CHANNEL_COUNT > 1) ? CH_W'(channel_sel) : '0;

    // operand selection for the shared multiplier
    always_comb
    begin
        unique case (ctl.a_sel)
            A_S4:    a_op = A_W'(w_reg[4]);
            A_SUM:   a_op = A_W'(B_W'(cur_reg) + B_W'(w_reg[0]));
            A_OLD:   a_op = A_W'(w_reg[1]);
            A_N4:    a_op = A_W'(nq_reg[LFP_STAGE_COUNT-1]);
            A_SQ:    a_op = A_W'(sq_reg);
            A_CUBE:  a_op = A_W'(cube_reg);
            default: a_op = '0;
        endcase
        unique case (ctl.b_sel)
            B_Q:     b_op = B_W'(coef_q);
            B_P:     b_op = B_W'(coef_p);
            B_F:     b_op = B_W'(coef_f);
            B_N4:    b_op = B_W'(nq_reg[LFP_STAGE_COUNT-1]);
            B_SIXTH: b_op = SIXTH;
            default: b_op = '0;
        endcase
    end

    assign prod = a_op * b_op;

    assign acc_rnd_coef  = (acc_reg + RND_COEF) >>> LFP_COEF_SHIFT;
    assign acc_rnd_sixth = (acc_reg + RND_SIXTH) >>> LFP_SIXTH_SHIFT;
    assign u_val         = sat_state(ACC_W'(x_reg) - acc_rnd_coef);
    assign stage_val     = sat_state(acc_rnd_coef);
    // soft clip: n4 minus cube/6
    assign clip_val      = sat_state(ACC_W'(nq_reg[LFP_STAGE_COUNT-1]) - acc_rnd_sixth);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg    <= X_W'(sample_in) <<< OUT_SHIFT;
            ch_reg   <= ch_idx;
            w_reg[0] <= state_reg[ch_idx].held;
            w_reg[1] <= state_reg[ch_idx].s1;
            w_reg[2] <= state_reg[ch_idx].s2;
            w_reg[3] <= state_reg[ch_idx].s3;
            w_reg[4] <= state_reg[ch_idx].s4;
        end

        unique case (ctl.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod);
            ACC_SUB:  acc_reg <= acc_reg - ACC_W'(prod);
            default:  acc_reg <= acc_reg;
        endcase

        unique case (ctl.wb_op)
            WB_U:
            begin
                u_reg   <= u_val;
                cur_reg <= u_val;
            end
            WB_STAGE:
            begin
                // shift so the next stage always finds its inputs at w[0], w[1]
                cur_reg <= stage_val;
                for (int i = 0; i < 4; i++)
                begin
                    w_reg[i] <= w_reg[i+1];
                end
                for (int i = 0; i < LFP_STAGE_COUNT - 1; i++)
                begin
                    nq_reg[i] <= nq_reg[i+1];
                end
                nq_reg[LFP_STAGE_COUNT-1] <= stage_val;
            end
            WB_SQ:    sq_reg   <= acc_reg[STATE_FRAC_BITS +: SQ_W];
            WB_CUBE:  cube_reg <= acc_reg[STATE_FRAC_BITS +: CUBE_W];
            WB_CLIP:  nq_reg[LFP_STAGE_COUNT-1] <= clip_val;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (ctl.wb_op == WB_OUT)
        begin
            state_reg[ch_reg].held <= u_reg;
            state_reg[ch_reg].s1   <= nq_reg[0];
            state_reg[ch_reg].s2   <= nq_reg[1];
            state_reg[ch_reg].s3   <= nq_reg[2];
            state_reg[ch_reg].s4   <= nq_reg[3];
        end
    end

    // output tap, rounded to 15 fraction bits and saturated
    always_comb
    begin
        band_diff = TAP_W'(nq_reg[2]) - TAP_W'(nq_reg[3]);
        unique case (output_mode)
            MODE_HP: tap = TAP_W'(u_reg) - TAP_W'(nq_reg[3]);
            MODE_BP: tap = (band_diff <<< 1) + band_diff;
            default: tap = TAP_W'(nq_reg[3]);
        endcase
        tap_rnd = (tap + OUT_HALF) >>> OUT_SHIFT;
        priority if (tap_rnd > OUT_HI)
        begin
            sample_out = OUT_HI[LFP_SAMPLE_W-1:0];
        end
        else if (tap_rnd < OUT_LO)
        begin
            sample_out = OUT_LO[LFP_SAMPLE_W-1:0];
        end
        else
        begin
            sample_out = tap_rnd[LFP_SAMPLE_W-1:0];
        end
    end

endmodule

/* dv/ladder_filter_four_pole_check.sv */
// ----------------------------------------------------------------------------
// ladder_filter_four_pole_check
// watches the sample streams and the register port, runs its own ladder
// filter per channel and compares every filtered sample in arrival order
// ----------------------------------------------------------------------------
module ladder_filter_four_pole_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [lfp_pkg::LFP_SAMPLE_W-1:0]    s_axis_tdata,  // sample_in
    input  logic [0:0]                          s_axis_tuser,  // channel_sel
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [lfp_pkg::LFP_SAMPLE_W-1:0]    m_axis_tdata,  // sample_out
    input  logic                                cfg_we,
    input  logic [lfp_pkg::LFP_CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lfp_pkg::LFP_COEF_W-1:0]      cfg_data,
    output int                                  failures,
    output int                                  pending
);
    import lfp_pkg::*;

    localparam longint STATE_MAX = (longint'(1) << (LFP_STATE_W - 1)) - 1;
    localparam longint STATE_MIN = -(longint'(1) << (LFP_STATE_W - 1));
    localparam longint OUT_MAX   = (longint'(1) << (LFP_SAMPLE_W - 1)) - 1;
    localparam longint OUT_MIN   = -(longint'(1) << (LFP_SAMPLE_W - 1));
    localparam int     TAP_SHIFT = LFP_STATE_FRAC_BITS - LFP_SAMPLE_FRAC;
    localparam int     REPORT_MAX = 10;

    logic signed [LFP_STATE_W-1:0] held_in [LFP_CHANNEL_COUNT];
    logic signed [LFP_STATE_W-1:0] pole1   [LFP_CHANNEL_COUNT];
    logic signed [LFP_STATE_W-1:0] pole2   [LFP_CHANNEL_COUNT];
    logic signed [LFP_STATE_W-1:0] pole3   [LFP_CHANNEL_COUNT];
    logic signed [LFP_STATE_W-1:0] pole4   [LFP_CHANNEL_COUNT];

    logic signed [LFP_COEF_W-1:0] gain_p;
    logic signed [LFP_COEF_W-1:0] damp_f;
    logic signed [LFP_COEF_W-1:0] reso_q;
    logic [LFP_MODE_W-1:0]        tap_mode;

    logic [LFP_SAMPLE_W-1:0] out_samples_due [$];
    logic [LFP_SAMPLE_W-1:0] want;
    int                      fail_count;
    int                      result_index;

    assign failures = fail_count;

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint ladder_stage(input longint a, input longint b,
                                            input longint old, input longint p,
                                            input longint f);
        return clamp(round_half_up((a + b) * p - old * f, LFP_COEF_SHIFT),
                     STATE_MIN, STATE_MAX);
    endfunction

    // one filter pass for the addressed channel, updates that channel's poles
    function automatic logic [LFP_SAMPLE_W-1:0] ladder_step(
        input logic [LFP_SAMPLE_W-1:0] smp,
        input logic [0:0]              ch_sel
    );
        int     c;
        longint p, f, q, x, u, o1, o2, o3, o4, n1, n2, n3, n4, sq, cube, tap;
        c  = int'(ch_sel) % LFP_CHANNEL_COUNT;
        p  = gain_p;
        f  = damp_f;
        q  = reso_q;
        o1 = pole1[c];
        o2 = pole2[c];
        o3 = pole3[c];
        o4 = pole4[c];
        x  = longint'($signed(smp)) * (longint'(1) << TAP_SHIFT);
        u  = clamp(x - round_half_up(q * o4, LFP_COEF_SHIFT), STATE_MIN, STATE_MAX);

        n1 = ladder_stage(u, held_in[c], o1, p, f);
        n2 = ladder_stage(n1, o1, o2, p, f);
        n3 = ladder_stage(n2, o2, o3, p, f);
        n4 = ladder_stage(n3, o3, o4, p, f);

        // soft clip: y - y^3/6, square and cube floored to state precision
        sq   = (n4 * n4) >>> LFP_STATE_FRAC_BITS;
        cube = (sq * n4) >>> LFP_STATE_FRAC_BITS;
        n4   = clamp(n4 - round_half_up(cube * LFP_SIXTH_Q16, LFP_SIXTH_SHIFT),
                     STATE_MIN, STATE_MAX);

        held_in[c] = u[LFP_STATE_W-1:0];
        pole1[c]   = n1[LFP_STATE_W-1:0];
        pole2[c]   = n2[LFP_STATE_W-1:0];
        pole3[c]   = n3[LFP_STATE_W-1:0];
        pole4[c]   = n4[LFP_STATE_W-1:0];

        case (tap_mode)
            MODE_HP: tap = u - n4;
            MODE_BP: tap = 3 * (n3 - n4);
            default: tap = n4;
        endcase
        tap = clamp(round_half_up(tap, TAP_SHIFT), OUT_MIN, OUT_MAX);
        return tap[LFP_SAMPLE_W-1:0];
    endfunction

    task automatic report_failure(input string what, input logic [LFP_SAMPLE_W-1:0] exp_val,
                                  input logic [LFP_SAMPLE_W-1:0] got_val);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("%0t: result %0d %s: expected %h, got %h",
                     $realtime, result_index, what, exp_val, got_val);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < LFP_CHANNEL_COUNT; c++)
            begin
                held_in[c] = '0;
                pole1[c]   = '0;
                pole2[c]   = '0;
                pole3[c]   = '0;
                pole4[c]   = '0;
            end
            gain_p   = '0;
            damp_f   = '0;
            reso_q   = '0;
            tap_mode = MODE_LP;
            out_samples_due.delete();
            pending <= 0;
        end
        else
        begin
            // drain first: an output here always belongs to an older request
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (out_samples_due.size() == 0)
                    report_failure("with nothing outstanding", 'x, m_axis_tdata);
                else
                begin
                    want = out_samples_due.pop_front();
                    if (m_axis_tdata !== want)
                        report_failure("sample_out mismatch", want, m_axis_tdata);
                end
                result_index++;
            end
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_COEF_P: gain_p   = cfg_data;
                    CFG_COEF_F: damp_f   = cfg_data;
                    CFG_COEF_Q: reso_q   = cfg_data;
                    CFG_MODE:   tap_mode = cfg_data[LFP_MODE_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                out_samples_due.push_back(ladder_step(s_axis_tdata, s_axis_tuser));
            pending <= out_samples_due.size();
        end
    end

    initial
    begin
        fail_count   = 0;
        result_index = 0;
    end

endmodule

/* dv/ladder_filter_four_pole_test.sv */
// ----------------------------------------------------------------------------
// ladder_filter_four_pole_test
// drives sample requests on both channels through directed corners and random
// coefficient phases in every output mode, with random source and sink stalls
// ----------------------------------------------------------------------------
module ladder_filter_four_pole_test;
    import lfp_pkg::*;

    // mode code left over by the block, falls back to lowpass
    localparam logic [LFP_MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 14;
    localparam int CALM_PHASES   = 2;
    localparam int PHASE_ITEMS   = 125;

    logic                       clk           = 1'b0;
    logic                       rst_n         = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [LFP_SAMPLE_W-1:0]    s_axis_tdata  = '0;  // sample_in
    logic [0:0]                 s_axis_tuser  = '0;  // channel_sel
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [LFP_SAMPLE_W-1:0]    m_axis_tdata;        // sample_out
    logic                       cfg_we        = 1'b0;
    logic [LFP_CFG_ADDR_W-1:0]  cfg_addr      = CFG_COEF_P;
    logic [LFP_COEF_W-1:0]      cfg_data      = '0;

    int   failures;
    int   pending;
    logic calm = 1'b0;

    logic [LFP_SAMPLE_W-1:0] corner_vals [5] = '{16'h7fff, 16'h8000, 16'h0000,
                                                 16'hffff, 16'h0001};

    ladder_filter_four_pole dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    ladder_filter_four_pole_check checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .pending       (pending)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // sink side: bursts of backpressure between ready stretches
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 60)) @(posedge clk);
        end
    end

    // valid stays high into the next request unless a gap is taken
    task automatic send_sample(input logic [LFP_SAMPLE_W-1:0] smp, input logic [0:0] ch);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= ch;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_coefs(input logic [LFP_COEF_W-1:0] p, input logic [LFP_COEF_W-1:0] f,
                              input logic [LFP_COEF_W-1:0] q,
                              input logic [LFP_MODE_W-1:0] mode);
        cfg_we   <= 1'b1;
        cfg_addr <= CFG_COEF_P;
        cfg_data <= p;
        @(posedge clk);
        cfg_addr <= CFG_COEF_F;
        cfg_data <= f;
        @(posedge clk);
        cfg_addr <= CFG_COEF_Q;
        cfg_data <= q;
        @(posedge clk);
        cfg_addr <= CFG_MODE;
        cfg_data <= LFP_COEF_W'(mode);
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic logic [LFP_COEF_W-1:0] wild_coef();
        case ($urandom_range(0, 3))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return LFP_COEF_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [LFP_SAMPLE_W-1:0] smp;
        logic [LFP_MODE_W-1:0]   mode;
        int                      pole;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // registers still at reset values
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b1);

        drain();
        load_coefs(16'h1000, 16'h0000, 16'h0000, MODE_LP);
        for (int i = 0; i < 5; i++)
            send_sample(corner_vals[i], 1'(i));

        drain();
        load_coefs(16'h0800, 16'hfc00, 16'h2000, MODE_HP);
        for (int i = 0; i < 4; i++)
            send_sample(corner_vals[i], 1'(i + 1));

        // coefficient extremes drive every stage into saturation
        drain();
        load_coefs(16'h7fff, 16'h8000, 16'h7fff, MODE_BP);
        for (int i = 0; i < 4; i++)
            send_sample(corner_vals[i], 1'(i));

        drain();
        load_coefs(16'h8000, 16'h7fff, 16'h8000, MODE_SPARE);
        for (int i = 0; i < 4; i++)
            send_sample(corner_vals[i + 1], 1'(i));

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            calm = (ph >= RANDOM_PHASES - CALM_PHASES);
            mode = LFP_MODE_W'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                load_coefs(wild_coef(), wild_coef(), wild_coef(), mode);
            else
            begin
                // usual tuning: f tracks 2p - 1, q below the self-oscillation region
                pole = $urandom_range(200, 3500);
                load_coefs(LFP_COEF_W'(pole), LFP_COEF_W'(2 * pole - 4096),
                           LFP_COEF_W'($urandom_range(0, 16384)), mode);
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 7))
                    0:       smp = corner_vals[$urandom_range(0, 4)];
                    1, 2:    smp = LFP_SAMPLE_W'($urandom_range(0, 8191) - 4096);
                    default: smp = LFP_SAMPLE_W'($urandom);
                endcase
                send_sample(smp, 1'($urandom_range(0, 1)));
            end
        end

        drain();
        if (failures == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
